[hdl/lfsbg_pkg.sv]
// ----------------------------------------------------------------------------
// lfsbg_pkg
// Shared types, codes and channel arithmetic for the LED frame store with
// brightness scaling and gamma correction.
// ----------------------------------------------------------------------------
package lfsbg_pkg;

    // field widths
    localparam int ACTION_W = 2;
    localparam int INDEX_W  = 8;
    localparam int CHAN_W   = 8;
    localparam int COLOUR_W = 3 * CHAN_W;
    localparam int POS_W    = 6;
    localparam int PCT_W    = 7;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 7;

    // products and intermediate widths
    localparam int PROD_W = CHAN_W + PCT_W;   // value * percent
    localparam int SQ_W   = 2 * CHAN_W;       // s * s + rounding

    // action codes
    typedef enum logic [ACTION_W-1:0] {
        ACT_SET   = 2'd0,
        ACT_FILL  = 2'd1,
        ACT_SHOW  = 2'd2,
        ACT_CLEAR = 2'd3
    } action_t;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BRIGHTNESS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAMMA      = 2'd1;

    localparam logic [PCT_W-1:0] PCT_MAX      = 7'd100;
    localparam logic [SQ_W-1:0]  GAMMA_ROUND  = 16'd127;
    localparam logic [12:0]      RECIP_100    = 13'd5243;   // 2^19 / 100, rounded up

    // controller to datapath
    typedef struct packed {
        logic                wr_en;
        logic                fill_en;
        logic                rd_en;
        logic                last;
        logic [POS_W-1:0]    addr;
        logic [COLOUR_W-1:0] colour;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic adv;
    } status_t;

    // floor(x / 100) for x up to 255 * 100
    function automatic logic [CHAN_W-1:0] div100(input logic [PROD_W-1:0] x);
        logic [PROD_W+12:0] t;
        t = x * RECIP_100;
        return t[26:19];
    endfunction

    // floor(y / 255) for y below 65280
    function automatic logic [CHAN_W-1:0] div255(input logic [SQ_W-1:0] y);
        logic [SQ_W:0] t;
        t = {1'b0, y} + {9'd0, y[SQ_W-1:8]} + 17'd1;
        return t[15:8];
    endfunction

endpackage

[hdl/lfsbg_ctrl.sv]
// ----------------------------------------------------------------------------
// lfsbg_ctrl
// Decodes input beats into store commands and walks the LED addresses
// during a show or clear.
// ----------------------------------------------------------------------------
module lfsbg_ctrl #(
    parameter int LED_COUNT = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [lfsbg_pkg::ACTION_W-1:0]  action,
    input  logic [lfsbg_pkg::INDEX_W-1:0]   pixel_index,
    input  logic [lfsbg_pkg::CHAN_W-1:0]    red,
    input  logic [lfsbg_pkg::CHAN_W-1:0]    green,
    input  logic [lfsbg_pkg::CHAN_W-1:0]    blue,
    input  lfsbg_pkg::status_t              status,
    output lfsbg_pkg::cmd_t                 cmd
);
    import lfsbg_pkg::*;

    localparam int AW = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(LED_COUNT - 1);
    localparam logic [INDEX_W:0] COUNT_LIM = (INDEX_W + 1)'(LED_COUNT);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SHOW = 1'b1;

    logic          state_reg, state_next;
    logic [AW-1:0] cnt_reg, cnt_next;
    logic          accept;
    logic          in_range;

    assign in_stall = (state_reg == ST_SHOW);
    assign accept   = in_valid && !in_stall;
    assign in_range = ({1'b0, pixel_index} < COUNT_LIM);

    // command decode and show sequencing
    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        cmd.wr_en   = 1'b0;
        cmd.fill_en = 1'b0;
        cmd.rd_en   = 1'b0;
        cmd.last    = 1'b0;
        cmd.addr    = pixel_index[POS_W-1:0];
        cmd.colour  = {red, green, blue};
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (action_t'(action))
                        ACT_SET:   cmd.wr_en = in_range;
                        ACT_FILL:  cmd.fill_en = 1'b1;
                        ACT_SHOW:  state_next = ST_SHOW;
                        ACT_CLEAR:
                        begin
                            cmd.fill_en = 1'b1;
                            cmd.colour  = '0;
                            state_next  = ST_SHOW;
                        end
                        default: ;
                    endcase
                    cnt_next = '0;
                end
            end
            ST_SHOW:
            begin
                cmd.addr = POS_W'(cnt_reg);
                cmd.last = (cnt_reg == LAST_ADDR);
                if (status.adv)
                begin
                    cmd.rd_en = 1'b1;
                    if (cnt_reg == LAST_ADDR)
                    begin
                        cnt_next   = '0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

[hdl/lfsbg_datapath.sv]
// ----------------------------------------------------------------------------
// lfsbg_datapath
// Pixel store with fill colour and per-entry valid bits, followed by a
// five-stage correction pipeline: read, scale, divide by 100, square,
// divide by 255 into the output register.
// ----------------------------------------------------------------------------
module lfsbg_datapath #(
    parameter int LED_COUNT = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  lfsbg_pkg::cmd_t                   cmd,
    output lfsbg_pkg::status_t                status,
    input  logic [lfsbg_pkg::PCT_W-1:0]       brightness,
    input  logic                              gamma_en,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [lfsbg_pkg::COLOUR_W-1:0]    grb_word,
    output logic [lfsbg_pkg::POS_W-1:0]       led_position,
    output logic                              last_word
);
    import lfsbg_pkg::*;

    localparam int AW = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;

    logic [COLOUR_W-1:0]  mem [LED_COUNT];
    logic [LED_COUNT-1:0] pix_valid_reg;
    logic [COLOUR_W-1:0]  fill_colour_reg;
    logic                 adv;
    logic [AW-1:0]        addr;

    // stage 1: store read
    logic                 v1_reg;
    logic [COLOUR_W-1:0]  mem_q_reg;
    logic [COLOUR_W-1:0]  fill1_reg;
    logic                 hit1_reg;
    logic [POS_W-1:0]     pos1_reg;
    logic                 last1_reg;
    // stage 2: value times percent
    logic                      v2_reg;
    logic [2:0][PROD_W-1:0]    prod2_reg;
    logic [POS_W-1:0]          pos2_reg;
    logic                      last2_reg;
    // stage 3: scaled value
    logic                      v3_reg;
    logic [2:0][CHAN_W-1:0]    s3_reg;
    logic [POS_W-1:0]          pos3_reg;
    logic                      last3_reg;
    // stage 4: square plus rounding
    logic                      v4_reg;
    logic [2:0][CHAN_W-1:0]    s4_reg;
    logic [2:0][SQ_W-1:0]      sq4_reg;
    logic [POS_W-1:0]          pos4_reg;
    logic                      last4_reg;
    // output register
    logic                      out_valid_reg;
    logic [COLOUR_W-1:0]       grb_reg;
    logic [POS_W-1:0]          pos_reg;
    logic                      last_reg;

    logic [COLOUR_W-1:0]       colour1;
    logic [2:0][CHAN_W-1:0]    chan_out;

    assign addr       = cmd.addr[AW-1:0];
    assign adv        = !out_valid_reg || !out_stall;
    assign status.adv = adv;

    // pixel memory
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[addr] <= cmd.colour;
        end
        if (adv)
        begin
            mem_q_reg <= mem[addr];
        end
    end

    // valid bits and fill colour
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pix_valid_reg   <= '0;
            fill_colour_reg <= '0;
        end
        else if (cmd.fill_en)
        begin
            pix_valid_reg   <= '0;
            fill_colour_reg <= cmd.colour;
        end
        else if (cmd.wr_en)
        begin
            pix_valid_reg[addr] <= 1'b1;
        end
    end

    // pipeline valids, all stages hold while a valid output is stalled
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg        <= cmd.rd_en;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            v4_reg        <= v3_reg;
            out_valid_reg <= v4_reg;
        end
    end

    // entries not written since the last fill read as the fill colour
    assign colour1 = hit1_reg ? mem_q_reg : fill1_reg;

    // final gamma select
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            chan_out[c] = (gamma_en && (s4_reg[c] != '0)) ? div255(sq4_reg[c]) : s4_reg[c];
        end
    end

    // pipeline payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            fill1_reg <= fill_colour_reg;
            hit1_reg  <= pix_valid_reg[addr];
            pos1_reg  <= cmd.addr;
            last1_reg <= cmd.last;

            for (int c = 0; c < 3; c++)
            begin
                prod2_reg[c] <= colour1[c*CHAN_W +: CHAN_W] * brightness;
            end
            pos2_reg  <= pos1_reg;
            last2_reg <= last1_reg;

            for (int c = 0; c < 3; c++)
            begin
                s3_reg[c] <= div100(prod2_reg[c]);
            end
            pos3_reg  <= pos2_reg;
            last3_reg <= last2_reg;

            for (int c = 0; c < 3; c++)
            begin
                s4_reg[c]  <= s3_reg[c];
                sq4_reg[c] <= (s3_reg[c] * s3_reg[c]) + GAMMA_ROUND;
            end
            pos4_reg  <= pos3_reg;
            last4_reg <= last3_reg;

            // channel 2 red, 1 green, 0 blue; packed green, red, blue
            grb_reg  <= {chan_out[1], chan_out[2], chan_out[0]};
            pos_reg  <= pos4_reg;
            last_reg <= last4_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign grb_word     = grb_reg;
    assign led_position = pos_reg;
    assign last_word    = last_reg;

endmodule

[hdl/led_frame_store_brightness_gamma.sv]
// ----------------------------------------------------------------------------
// led_frame_store_brightness_gamma
// Frame store of RGB colours, one per LED, with brightness scaling and
// square-law gamma on readout.
//
//   channel   direction   handshake            payload
//   in        input       in_valid/in_stall    action, pixel_index, red, green, blue
//   out       output      out_valid/out_stall  grb_word, led_position, last_word
//   cfg       input       cfg_valid/cfg_ready  cfg_index, cfg_data
//
// Set pixel and fill act as their beat is taken; fill marks every entry stale at once.
// Show and clear take the beat, then do one store read per cycle for each LED
// in turn, pausing while a valid output word is stalled. Each word then passes
// through the correction pipeline to the output.
// Reset clears the frame to black, brightness to 100 and enables gamma.
// A stall on the output holds the whole correction pipeline and the read
// address sequencer; the input is stalled while a frame is being read out.
// ----------------------------------------------------------------------------
module led_frame_store_brightness_gamma #(
    parameter int LED_COUNT = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [lfsbg_pkg::ACTION_W-1:0]    action,
    input  logic [lfsbg_pkg::INDEX_W-1:0]     pixel_index,
    input  logic [lfsbg_pkg::CHAN_W-1:0]      red,
    input  logic [lfsbg_pkg::CHAN_W-1:0]      green,
    input  logic [lfsbg_pkg::CHAN_W-1:0]      blue,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [lfsbg_pkg::COLOUR_W-1:0]    grb_word,
    output logic [lfsbg_pkg::POS_W-1:0]       led_position,
    output logic                              last_word,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [lfsbg_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [lfsbg_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import lfsbg_pkg::*;

    cmd_t             cmd;
    status_t          status;
    logic [PCT_W-1:0] brightness_reg;
    logic             gamma_reg;
    logic             cfg_wr;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;

    // configuration registers, brightness saturates at 100
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            brightness_reg <= PCT_MAX;
            gamma_reg      <= 1'b1;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_index)
                CFG_BRIGHTNESS: brightness_reg <= (cfg_data > PCT_MAX) ? PCT_MAX : cfg_data;
                CFG_GAMMA:      gamma_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    lfsbg_ctrl #(
        .LED_COUNT (LED_COUNT)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .action      (action),
        .pixel_index (pixel_index),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .status      (status),
        .cmd         (cmd)
    );

    lfsbg_datapath #(
        .LED_COUNT (LED_COUNT)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .brightness   (brightness_reg),
        .gamma_en     (gamma_reg),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .grb_word     (grb_word),
        .led_position (led_position),
        .last_word    (last_word)
    );

endmodule

[test/tb_led_frame_store_brightness_gamma.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_led_frame_store_brightness_gamma
// Self-checking bench for the LED frame store. A behavioral copy of the pixel
// store and the brightness/gamma path predicts every LED word of each show or
// clear. Directed checks cover reset, pixel writes, fill, clear and the
// register extremes. Random traffic runs under several idle and stall mixes,
// and a long output hold fills the block so that it stalls its input.
// ----------------------------------------------------------------------------
module tb_led_frame_store_brightness_gamma;

    import lfsbg_pkg::*;

    localparam int LED_COUNT     = 32;
    localparam int SETTLE_CYCLES = 12;
    localparam int HOLD_CYCLES   = 400;
    localparam int STALL_LIMIT   = 4000;

    // register indexes that map to nothing
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_B = 2'd3;

    typedef struct {
        logic [COLOUR_W-1:0] grb;
        logic [POS_W-1:0]    pos;
        logic                last;
    } led_word_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    logic [ACTION_W-1:0]    action = '0;
    logic [INDEX_W-1:0]     pixel_index = '0;
    logic [CHAN_W-1:0]      red = '0;
    logic [CHAN_W-1:0]      green = '0;
    logic [CHAN_W-1:0]      blue = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic [COLOUR_W-1:0]    grb_word;
    logic [POS_W-1:0]       led_position;
    logic                   last_word;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    // shadow of the block state
    logic [COLOUR_W-1:0]    frame_colours [LED_COUNT];
    int unsigned            brightness_pct = 100;
    logic                   gamma_on = 1'b1;
    led_word_t              pending_words [$];

    int                     mismatches = 0;
    int                     send_idle_pct = 0;
    int                     recv_stall_pct = 0;
    logic                   hold_toggle = 1'b0;
    logic                   hold_seen = 1'b0;
    int                     hold_left = 0;
    int                     quiet_cycles = 0;

    led_frame_store_brightness_gamma #(
        .LED_COUNT(LED_COUNT)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .action(action),
        .pixel_index(pixel_index),
        .red(red),
        .green(green),
        .blue(blue),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .grb_word(grb_word),
        .led_position(led_position),
        .last_word(last_word),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // brightness scale, then square-law gamma on nonzero values
    function automatic logic [CHAN_W-1:0] corrected_channel(input logic [CHAN_W-1:0] v);
        int unsigned s;
        s = (v * brightness_pct) / 100;
        if (gamma_on && s != 0)
            s = (s * s + 127) / 255;
        return s[CHAN_W-1:0];
    endfunction

    // one word per led, in index order
    function automatic void predict_frame();
        led_word_t w;
        logic [COLOUR_W-1:0] c;
        for (int i = 0; i < LED_COUNT; i++)
        begin
            c = frame_colours[i];
            w.grb = {corrected_channel(c[15:8]), corrected_channel(c[23:16]),
                     corrected_channel(c[7:0])};
            w.pos = POS_W'(i);
            w.last = (i == LED_COUNT - 1);
            pending_words.push_back(w);
        end
    endfunction

    function automatic void update_frame(input action_t act, input logic [INDEX_W-1:0] idx,
                                         input logic [COLOUR_W-1:0] colour);
        case (act)
            ACT_SET:
                if (idx < LED_COUNT)
                    frame_colours[idx] = colour;
            ACT_FILL:
                foreach (frame_colours[i]) frame_colours[i] = colour;
            ACT_SHOW:
                predict_frame();
            ACT_CLEAR:
            begin
                foreach (frame_colours[i]) frame_colours[i] = '0;
                predict_frame();
            end
        endcase
    endfunction

    // offer one input beat, with random idle cycles ahead of it
    task automatic send_beat(input action_t act, input logic [INDEX_W-1:0] idx,
                             input logic [CHAN_W-1:0] r, input logic [CHAN_W-1:0] g,
                             input logic [CHAN_W-1:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        action      <= act;
        pixel_index <= idx;
        red         <= r;
        green       <= g;
        blue        <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        update_frame(act, idx, {r, g, b});
    endtask

    // register write; keep_valid chains the next write without a gap
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data, input bit keep_valid);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_BRIGHTNESS: brightness_pct = 32'((data > PCT_MAX) ? PCT_MAX : data);
            CFG_GAMMA:      gamma_on = data[0];
            default:        ;
        endcase
        if (!keep_valid)
            cfg_valid <= 1'b0;
    endtask

    task automatic configure(input logic [CFG_DATA_W-1:0] pct, input logic gam);
        write_reg(CFG_BRIGHTNESS, pct, 1'b1);
        write_reg(CFG_GAMMA, {6'($urandom), gam}, 1'b0);
    endtask

    // drain every expected word, then let the pipeline settle
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic test_reset_frame();
        send_beat(ACT_SHOW, 8'hff, 8'hff, 8'hff, 8'hff);
        wait_idle();
    endtask

    task automatic test_pixel_writes();
        send_beat(ACT_SET, 8'd0, 8'hff, 8'hff, 8'hff);
        send_beat(ACT_SET, 8'(LED_COUNT - 1), 8'h00, 8'h80, 8'h01);
        send_beat(ACT_SET, 8'd1, 8'h7f, 8'h01, 8'h80);
        // out of range indexes leave the store alone
        send_beat(ACT_SET, 8'(LED_COUNT), 8'h12, 8'h34, 8'h56);
        send_beat(ACT_SET, 8'hff, 8'h55, 8'haa, 8'h55);
        send_beat(ACT_SHOW, 8'h00, 8'h00, 8'h00, 8'h00);
        wait_idle();
    endtask

    task automatic test_fill_and_clear();
        send_beat(ACT_FILL, 8'h00, 8'haa, 8'h55, 8'hff);
        send_beat(ACT_SET, 8'd5, 8'h01, 8'h02, 8'h03);
        send_beat(ACT_SHOW, 8'ha5, 8'h5a, 8'hc3, 8'h3c);
        // clear ignores its colour fields
        send_beat(ACT_CLEAR, 8'h3c, 8'hff, 8'hff, 8'hff);
        send_beat(ACT_SHOW, 8'h00, 8'h00, 8'h00, 8'h00);
        wait_idle();
    endtask

    task automatic test_register_settings();
        send_beat(ACT_FILL, 8'h00, 8'hff, 8'h80, 8'h01);
        wait_idle();
        // zero brightness with gamma
        configure(7'd0, 1'b1);
        send_beat(ACT_SHOW, 8'h00, 8'h00, 8'h00, 8'h00);
        wait_idle();
        // write above the maximum saturates, gamma off
        configure(7'd127, 1'b0);
        send_beat(ACT_SHOW, 8'h00, 8'h00, 8'h00, 8'h00);
        wait_idle();
        configure(7'd1, 1'b1);
        send_beat(ACT_SET, 8'd7, 8'hff, 8'hff, 8'hff);
        send_beat(ACT_SHOW, 8'h00, 8'h00, 8'h00, 8'h00);
        wait_idle();
        configure(7'd101, 1'b1);
        wait_idle();
        // unmapped indexes change nothing
        write_reg(CFG_UNMAPPED_A, 7'd5, 1'b1);
        write_reg(CFG_UNMAPPED_B, 7'd0, 1'b0);
        send_beat(ACT_SHOW, 8'h00, 8'h00, 8'h00, 8'h00);
        wait_idle();
        configure(7'd50, 1'b0);
        send_beat(ACT_SHOW, 8'h00, 8'h00, 8'h00, 8'h00);
        wait_idle();
    endtask

    task automatic random_items(input int count);
        int pick;
        action_t act;
        logic [INDEX_W-1:0] idx;
        repeat (count)
        begin
            pick = $urandom_range(99);
            act = (pick < 55) ? ACT_SET : (pick < 65) ? ACT_FILL :
                  (pick < 90) ? ACT_SHOW : ACT_CLEAR;
            idx = ($urandom_range(99) < 85) ? INDEX_W'($urandom_range(LED_COUNT - 1))
                                            : INDEX_W'($urandom);
            send_beat(act, idx, 8'($urandom), 8'($urandom), 8'($urandom));
        end
    endtask

    task automatic random_phase(input int idle_pct, input int stall_pct,
                                input logic [CFG_DATA_W-1:0] pct, input logic gam);
        configure(pct, gam);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        random_items(24);
        wait_idle();
    endtask

    task automatic test_random_traffic();
        random_phase(0, 0, 7'd100, 1'b1);
        random_phase(51, 0, 7'd37, 1'b1);
        random_phase(0, 51, 7'd73, 1'b0);
        random_phase(27, 27, 7'd100, 1'b0);
    endtask

    task automatic test_output_hold();
        configure(7'd88, 1'b1);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_toggle <= ~hold_toggle;
        send_beat(ACT_SHOW, 8'h00, 8'h00, 8'h00, 8'h00);
        send_beat(ACT_SET, 8'd3, 8'hc0, 8'h30, 8'h0c);
        send_beat(ACT_SET, 8'd30, 8'hff, 8'h00, 8'hff);
        send_beat(ACT_SHOW, 8'h00, 8'h00, 8'h00, 8'h00);
        send_beat(ACT_CLEAR, 8'hff, 8'hff, 8'hff, 8'hff);
        send_beat(ACT_SHOW, 8'h00, 8'h00, 8'h00, 8'h00);
        wait_idle();
    endtask

    // output beat check and stall generation
    always @(posedge clk)
    begin
        led_word_t exp_word;
        if (out_valid && !out_stall)
        begin
            if (pending_words.size() == 0)
            begin
                $error("unexpected led word: grb_word %06h led_position %0d",
                       grb_word, led_position);
                mismatches++;
            end
            else
            begin
                exp_word = pending_words.pop_front();
                if (grb_word !== exp_word.grb)
                begin
                    $error("grb_word mismatch: expected %06h, actual %06h",
                           exp_word.grb, grb_word);
                    mismatches++;
                end
                if (led_position !== exp_word.pos)
                begin
                    $error("led_position mismatch: expected %0d, actual %0d",
                           exp_word.pos, led_position);
                    mismatches++;
                end
                if (last_word !== exp_word.last)
                begin
                    $error("last_word mismatch: expected %0b, actual %0b",
                           exp_word.last, last_word);
                    mismatches++;
                end
            end
        end
        if (hold_seen != hold_toggle)
        begin
            hold_seen <= hold_toggle;
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // watchdog on cycles without any beat
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    // test sequence
    initial
    begin
        foreach (frame_colours[i]) frame_colours[i] = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_frame();
        test_pixel_writes();
        test_fill_and_clear();
        test_register_settings();
        test_random_traffic();
        test_output_hold();
        wait_idle();
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

[files.f]
hdl/lfsbg_pkg.sv
hdl/lfsbg_ctrl.sv
hdl/lfsbg_datapath.sv
hdl/led_frame_store_brightness_gamma.sv
test/tb_led_frame_store_brightness_gamma.sv
